### hdl/mit_pkg.sv
// shared types, constants and the step program of the mesh inertia tensor unit
// no dependencies; used by mit_ctrl and mit_datapath
package mit_pkg;

    localparam int unsigned COORD_W   = 16;
    localparam int unsigned N_COORDS  = 9;
    localparam int unsigned IN_DATA_W = COORD_W * N_COORDS;
    localparam int unsigned R_W       = 17;   // vertex minus centre
    localparam int unsigned S_W       = 19;   // sum of three offsets
    localparam int unsigned A_W       = 36;   // multiplier operand a
    localparam int unsigned B_W       = 28;   // multiplier operand b
    localparam int unsigned P_W       = A_W + B_W;
    localparam int unsigned CR_W      = 36;   // cross product terms
    localparam int unsigned DET_W     = 54;
    localparam int unsigned M_W       = 40;   // second-moment entries
    localparam int unsigned ACC_W     = 96;
    localparam int unsigned SUM_W     = 64;
    localparam int unsigned LANES     = 6;
    localparam int unsigned OUT_DATA_W = SUM_W * LANES;
    localparam int unsigned DH_LO     = 27;   // det split point
    localparam int unsigned MH_LO     = 20;   // moment split point
    localparam int unsigned DIV_CONST = 120;
    localparam int unsigned REM_W     = 7;
    localparam int unsigned STEP_W    = 6;
    localparam int unsigned LAST_STEP = 57;
    localparam int unsigned CFG_IDX_W = 2;

    // divide by 120 sixteen bits at a time: digit = (rem:chunk * ceil(2^30/120)) >> 30
    localparam int unsigned DIV_CHUNK_W  = 16;
    localparam int unsigned DIV_STEPS    = SUM_W / DIV_CHUNK_W;
    localparam int unsigned TRIAL_W      = REM_W + DIV_CHUNK_W;
    localparam int unsigned RECIP_W      = 24;
    localparam int unsigned RECIP_PROD_W = TRIAL_W + RECIP_W;
    localparam int unsigned RECIP_SH     = 30;
    localparam logic [RECIP_W-1:0] DIV_RECIP = 24'd8947849;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 2'd2;

    typedef enum logic [2:0] {OPA_R, OPA_C, OPA_S, OPA_DH, OPA_DL} opa_t;
    typedef enum logic [1:0] {OPB_R, OPB_S, OPB_MH, OPB_ML} opb_t;
    typedef enum logic [1:0] {SH_0, SH_20, SH_27, SH_47} shift_t;
    typedef enum logic [2:0] {DST_NONE, DST_CX, DST_CY, DST_CZ, DST_DET, DST_M} dest_t;
    typedef enum logic [2:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_PAIR, ST_DIV, ST_HOLD} state_t;

    typedef struct packed {
        opa_t       a_sel;
        logic [3:0] a_idx;
        opb_t       b_sel;
        logic [3:0] b_idx;
        shift_t     shift;
        logic       first;
        logic       neg;
        dest_t      dest;
        logic [2:0] dst_idx;
        logic       commit;
        logic [2:0] commit_idx;
    } prog_row_t;

    typedef struct packed {
        logic      load;
        prog_row_t row;
        logic      pair_load;
        logic      div_step;
        logic      out_load;
    } dp_cmd_t;

    // operand indexes of the three cross product terms, two products each
    localparam logic [3:0] CR_A [0:5] = '{4'd4, 4'd5, 4'd5, 4'd3, 4'd3, 4'd4};
    localparam logic [3:0] CR_B [0:5] = '{4'd8, 4'd7, 4'd6, 4'd8, 4'd7, 4'd6};
    // row and column of the six unique moment entries: xx yy zz xy yz xz
    localparam logic [1:0] M_I [0:5] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd0};
    localparam logic [1:0] M_J [0:5] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

    // one multiply step of the per-triangle program
    function automatic prog_row_t prog_row(input logic [STEP_W-1:0] step);
        prog_row_t          row;
        logic [STEP_W-1:0]  k;
        logic [2:0]         n;
        logic [1:0]         ph;
        logic [1:0]         vi;
        logic [1:0]         vj;
        row = '0;
        k   = '0;
        n   = '0;
        ph  = '0;
        vi  = '0;
        vj  = '0;
        if (step < STEP_W'(6)) begin
            // cross product r1 x r2
            row.a_sel = OPA_R;
            row.b_sel = OPB_R;
            row.a_idx = CR_A[step[2:0]];
            row.b_idx = CR_B[step[2:0]];
            row.first = ~step[0];
            row.neg   = step[0];
            if (step[0]) begin
                case (step[2:1])
                    2'd0:    row.dest = DST_CX;
                    2'd1:    row.dest = DST_CY;
                    default: row.dest = DST_CZ;
                endcase
            end
        end else if (step < STEP_W'(9)) begin
            // determinant r0 . (r1 x r2)
            k = step - STEP_W'(6);
            row.a_sel = OPA_C;
            row.a_idx = {2'b00, k[1:0]};
            row.b_sel = OPB_R;
            row.b_idx = {2'b00, k[1:0]};
            row.first = (k == '0);
            if (k == STEP_W'(2)) begin
                row.dest = DST_DET;
            end
        end else if (step < STEP_W'(33)) begin
            // second-moment entries, four products each
            k  = step - STEP_W'(9);
            n  = k[4:2];
            ph = k[1:0];
            vi = M_I[n];
            vj = M_J[n];
            if (ph == 2'd0) begin
                row.a_sel = OPA_S;
                row.b_sel = OPB_S;
                row.a_idx = {2'b00, vi};
                row.b_idx = {2'b00, vj};
                row.first = 1'b1;
            end else begin
                row.a_sel = OPA_R;
                row.b_sel = OPB_R;
                row.a_idx = 4'(({2'b00, ph} - 4'd1) * 4'd3) + {2'b00, vi};
                row.b_idx = 4'(({2'b00, ph} - 4'd1) * 4'd3) + {2'b00, vj};
            end
            if (ph == 2'd3) begin
                row.dest    = DST_M;
                row.dst_idx = n;
            end
        end else if (step < STEP_W'(LAST_STEP)) begin
            // det times moment entry as four partial products
            k  = step - STEP_W'(33);
            n  = k[4:2];
            ph = k[1:0];
            row.a_sel = ph[1] ? OPA_DL : OPA_DH;
            row.b_sel = ph[0] ? OPB_ML : OPB_MH;
            row.b_idx = {1'b0, n};
            case (ph)
                2'd0:    row.shift = SH_47;
                2'd1:    row.shift = SH_27;
                2'd2:    row.shift = SH_20;
                default: row.shift = SH_0;
            endcase
            row.first = (ph == 2'd0);
            if (ph == 2'd0 && n != 3'd0) begin
                row.commit     = 1'b1;
                row.commit_idx = n - 3'd1;
            end
        end else begin
            // fold in the last entry
            row.commit     = 1'b1;
            row.commit_idx = 3'd5;
        end
        return row;
    endfunction

endpackage

### hdl/mit_ctrl.sv
// controller of the mesh inertia tensor unit: sequences the multiply program,
// the final pair sums, the division by 120 and the output register; uses mit_pkg
module mit_ctrl
    import mit_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  logic    in_last,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              last_reg, last_next;
    logic              out_valid_reg, out_valid_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    last_next  = in_last;
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.row = prog_row(cnt_reg);
                if (cnt_reg == STEP_W'(LAST_STEP))
                begin
                    state_next = last_reg ? ST_DRAIN : ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + STEP_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_PAIR;
            end
            ST_PAIR:
            begin
                cmd.pair_load = 1'b1;
                cnt_next      = '0;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + STEP_W'(1);
                if (cnt_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

### hdl/mit_datapath.sv
// datapath of the mesh inertia tensor unit: centre registers, shared multiplier,
// wide accumulator, saturating sums and six chunked dividers by 120; uses mit_pkg
module mit_datapath
    import mit_pkg::*;
#(
    parameter int unsigned TERM_SHIFT = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  dp_cmd_t                 cmd,
    input  logic [IN_DATA_W-1:0]    in_data,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [COORD_W-1:0]      cfg_data,
    output logic [OUT_DATA_W-1:0]   out_data
);

    logic signed [COORD_W-1:0] cen_reg [3];
    logic signed [R_W-1:0]     r_reg   [N_COORDS];
    logic signed [R_W-1:0]     r_next  [N_COORDS];
    logic signed [S_W-1:0]     s_w     [3];
    logic signed [CR_W-1:0]    c_reg   [3];
    logic signed [DET_W-1:0]   det_reg;
    logic signed [M_W-1:0]     m_reg   [LANES];
    logic signed [A_W-1:0]     a_op;
    logic signed [B_W-1:0]     b_op;
    logic signed [P_W-1:0]     prod_reg;
    prog_row_t                 row_reg;
    logic signed [ACC_W-1:0]   term;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [ACC_W-1:0]   shifted;
    logic signed [SUM_W-1:0]   term_sat;
    logic signed [SUM_W-1:0]   sum_reg [LANES];
    logic signed [SUM_W-1:0]   pair_v  [LANES];
    logic [SUM_W-1:0]          q_reg   [LANES];
    logic [REM_W-1:0]          rem_reg [LANES];
    logic                      neg_reg [LANES];
    logic [SUM_W-1:0]          res_reg [LANES];

    function automatic logic signed [SUM_W-1:0] sat_add64(
        input logic signed [SUM_W-1:0] a,
        input logic signed [SUM_W-1:0] b
    );
        logic signed [SUM_W:0] s;
        s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        if (s[SUM_W] != s[SUM_W-1])
        begin
            return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        return s[SUM_W-1:0];
    endfunction

    // centre registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cen_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CENTER_X: cen_reg[0] <= cfg_data;
                REG_CENTER_Y: cen_reg[1] <= cfg_data;
                REG_CENTER_Z: cen_reg[2] <= cfg_data;
                default:      ;
            endcase
        end
    end

    // vertex offsets and their sums
    for (genvar g = 0; g < N_COORDS; g++)
    begin : g_off
        assign r_next[g] = R_W'($signed(in_data[g*COORD_W +: COORD_W])) - R_W'(cen_reg[g % 3]);
    end
    for (genvar g = 0; g < 3; g++)
    begin : g_sum
        assign s_w[g] = S_W'(r_reg[g]) + S_W'(r_reg[3 + g]) + S_W'(r_reg[6 + g]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < N_COORDS; i++)
            begin
                r_reg[i] <= r_next[i];
            end
        end
    end

    // operand selection
    always_comb
    begin
        unique case (cmd.row.a_sel)
            OPA_R:   a_op = A_W'(r_reg[cmd.row.a_idx]);
            OPA_C:   a_op = A_W'(c_reg[cmd.row.a_idx[1:0]]);
            OPA_S:   a_op = A_W'(s_w[cmd.row.a_idx[1:0]]);
            OPA_DH:  a_op = A_W'($signed(det_reg[DET_W-1:DH_LO]));
            OPA_DL:  a_op = A_W'($signed({1'b0, det_reg[DH_LO-1:0]}));
            default: a_op = '0;
        endcase
        unique case (cmd.row.b_sel)
            OPB_R:   b_op = B_W'(r_reg[cmd.row.b_idx]);
            OPB_S:   b_op = B_W'(s_w[cmd.row.b_idx[1:0]]);
            OPB_MH:  b_op = B_W'($signed(m_reg[cmd.row.b_idx[2:0]][M_W-1:MH_LO]));
            OPB_ML:  b_op = B_W'($signed({1'b0, m_reg[cmd.row.b_idx[2:0]][MH_LO-1:0]}));
            default: b_op = '0;
        endcase
    end

    // shared multiplier
    always_ff @(posedge clk)
    begin
        prod_reg <= a_op * b_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
        end
        else
        begin
            row_reg <= cmd.row;
        end
    end

    // shifted product into the wide accumulator
    always_comb
    begin
        case (row_reg.shift)
            SH_0:    term = ACC_W'(prod_reg);
            SH_20:   term = ACC_W'(prod_reg) <<< MH_LO;
            SH_27:   term = ACC_W'(prod_reg) <<< DH_LO;
            default: term = ACC_W'(prod_reg) <<< (DH_LO + MH_LO);
        endcase
        acc_next = (row_reg.first ? ACC_W'(0) : acc_reg) + (row_reg.neg ? -term : term);
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        case (row_reg.dest)
            DST_CX:  c_reg[0] <= acc_next[CR_W-1:0];
            DST_CY:  c_reg[1] <= acc_next[CR_W-1:0];
            DST_CZ:  c_reg[2] <= acc_next[CR_W-1:0];
            DST_DET: det_reg  <= acc_next[DET_W-1:0];
            DST_M:   m_reg[row_reg.dst_idx] <= acc_next[M_W-1:0];
            default: ;
        endcase
    end

    // floor shift and saturation of a finished term
    always_comb
    begin
        shifted = acc_reg >>> TERM_SHIFT;
        if ((&shifted[ACC_W-1:SUM_W-1]) || !(|shifted[ACC_W-1:SUM_W-1]))
        begin
            term_sat = shifted[SUM_W-1:0];
        end
        else
        begin
            term_sat = shifted[ACC_W-1] ? {1'b1, {(SUM_W-1){1'b0}}}
                                        : {1'b0, {(SUM_W-1){1'b1}}};
        end
    end

    // running sums: xx yy zz then xy yz xz
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else if (cmd.pair_load)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else if (row_reg.commit)
        begin
            sum_reg[row_reg.commit_idx] <= sat_add64(sum_reg[row_reg.commit_idx], term_sat);
        end
    end

    // diagonal pair sums
    always_comb
    begin
        pair_v[0] = sat_add64(sum_reg[1], sum_reg[2]);
        pair_v[1] = sat_add64(sum_reg[0], sum_reg[2]);
        pair_v[2] = sat_add64(sum_reg[0], sum_reg[1]);
        pair_v[3] = sum_reg[3];
        pair_v[4] = sum_reg[4];
        pair_v[5] = sum_reg[5];
    end

    // division of the magnitudes by 120, sixteen bits a cycle from the top,
    // each quotient digit by reciprocal multiplication
    for (genvar l = 0; l < LANES; l++)
    begin : g_div
        logic [TRIAL_W-1:0]      trial;
        logic [RECIP_PROD_W-1:0] recip_prod;
        logic [DIV_CHUNK_W-1:0]  q_digit;
        logic [TRIAL_W-1:0]      q_back;
        logic                    flip;
        assign trial      = {rem_reg[l], q_reg[l][SUM_W-1 -: DIV_CHUNK_W]};
        assign recip_prod = RECIP_PROD_W'(trial) * RECIP_PROD_W'(DIV_RECIP);
        assign q_digit    = recip_prod[RECIP_SH +: DIV_CHUNK_W];
        assign q_back     = TRIAL_W'(q_digit) * TRIAL_W'(DIV_CONST);
        assign flip       = (l >= 3);

        always_ff @(posedge clk)
        begin
            if (cmd.pair_load)
            begin
                neg_reg[l] <= pair_v[l][SUM_W-1];
                q_reg[l]   <= pair_v[l][SUM_W-1] ? -pair_v[l] : pair_v[l];
                rem_reg[l] <= '0;
            end
            else if (cmd.div_step)
            begin
                rem_reg[l] <= REM_W'(trial - q_back);
                q_reg[l]   <= {q_reg[l][SUM_W-DIV_CHUNK_W-1:0], q_digit};
            end
            // off-diagonal entries carry the minus sign of the tensor
            if (cmd.out_load)
            begin
                res_reg[l] <= (neg_reg[l] ^ flip) ? -q_reg[l] : q_reg[l];
            end
        end

        assign out_data[l*SUM_W +: SUM_W] = res_reg[l];
    end

endmodule

### hdl/mesh_inertia_tensor_unit.sv
// Mesh inertia tensor unit. Accepts one triangle (three Q7.8 vertices) per request and
// accumulates the six inertia tensor sums; on a triangle flagged by tlast it returns the
// six unique tensor entries (units of 2^-8) and clears the sums. A triangle occupies the
// input while it is taken and for the 58 steps of the single shared 36x28 multiplier
// that forms the cross products, the determinant, the moment matrix and the wide
// det-times-moment products. A final triangle also holds the input through drain, pair
// sums, four steps of the sixteen-bit-a-cycle divide by 120 and output load. The result
// sits in an output register, so the next triangle is taken while it waits; a further
// final triangle waits for that register to be emptied. Config writes are always ready.
// Depends on mit_pkg, mit_ctrl and mit_datapath.
module mesh_inertia_tensor_unit
    import mit_pkg::*;
#(
    parameter int unsigned TERM_SHIFT = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
    input  logic [IN_DATA_W-1:0]    s_axis_tdata,
    input  logic                    s_axis_tlast,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // ixx, iyy, izz, ixy, iyz, ixz
    output logic [OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [COORD_W-1:0]      cfg_data
);

    dp_cmd_t cmd;

    assign cfg_ready = 1'b1;

    mit_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_last   (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    mit_datapath #(
        .TERM_SHIFT (TERM_SHIFT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (s_axis_tdata),
        .cfg_write (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (m_axis_tdata)
    );

endmodule

### hdl/mit_checker.sv
// port-level checks of the mesh inertia tensor unit, bound to the top level
// depends on mit_pkg and mesh_inertia_tensor_unit
module mit_checker
    import mit_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    input  logic                    s_axis_tready,
    input  logic                    s_axis_tlast,
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    input  logic [OUT_DATA_W-1:0]   m_axis_tdata
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // an accepted triangle is worked on before the next is taken; back-to-back accepts are flagged
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken on back-to-back cycles");

    // an ordinary triangle raises no result
    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tlast && !m_axis_tvalid
        |=> !m_axis_tvalid)
        else $error("result without a last triangle");

endmodule

bind mesh_inertia_tensor_unit mit_checker u_mit_checker (.*);

### verif/tb_mesh_inertia_tensor_unit.sv
// self-checking testbench for mesh_inertia_tensor_unit: random and directed triangle meshes
// predicted by a scoreboard class; depends on mit_pkg and the unit's RTL
`timescale 1ns / 100ps

module tb_mesh_inertia_tensor_unit;
    import mit_pkg::*;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic                        last;
        logic [N_COORDS-1:0][15:0]   v;    // a_x in v[0] up to c_z in v[8]
    } triangle_t;

    typedef logic [LANES-1:0][SUM_W-1:0] tensor_t;   // ixx iyy izz ixy iyz ixz

    // tensor predictor and store of expected tensors
    class tensor_scoreboard;
        longint signed diag_acc[3];
        longint signed cross_acc[3];
        longint signed center[3];
        tensor_t       tensor_q[$];
        int            errors;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
            if (idx == REG_CENTER_X) center[0] = longint'($signed(val));
            else if (idx == REG_CENTER_Y) center[1] = longint'($signed(val));
            else if (idx == REG_CENTER_Z) center[2] = longint'($signed(val));
        endfunction

        // exact product, floor shift by 32, clamp to 64 bits
        function longint signed scaled_product(longint signed a, longint signed b);
            logic signed [127:0] wa;
            logic signed [127:0] wb;
            logic signed [127:0] q;
            logic signed [127:0] hi;
            logic signed [127:0] lo;
            wa = a;
            wb = b;
            hi = 64'sh7FFF_FFFF_FFFF_FFFF;
            lo = -hi - 1;
            q  = (wa * wb) >>> 32;
            if (q > hi) return 64'sh7FFF_FFFF_FFFF_FFFF;
            if (q < lo) return 64'sh8000_0000_0000_0000;
            return q[63:0];
        endfunction

        function longint signed clamp_add(longint signed a, longint signed b);
            logic signed [64:0] x;
            logic signed [64:0] y;
            logic signed [64:0] t;
            x = a;
            y = b;
            t = x + y;
            if (t > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
            if (t < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
            return t[63:0];
        endfunction

        function int pending();
            return tensor_q.size();
        endfunction

        // accumulate one accepted triangle, queue a tensor on the final one
        function void note_triangle(triangle_t t);
            longint signed r[3][3];
            longint signed s[3];
            longint signed m[3][3];
            longint signed cx, cy, cz, det;
            tensor_t       res;
            for (int k = 0; k < 3; k++)
                for (int i = 0; i < 3; i++)
                    r[k][i] = longint'($signed(t.v[k*3+i])) - center[i];
            cx  = r[1][1]*r[2][2] - r[1][2]*r[2][1];
            cy  = r[1][2]*r[2][0] - r[1][0]*r[2][2];
            cz  = r[1][0]*r[2][1] - r[1][1]*r[2][0];
            det = r[0][0]*cx + r[0][1]*cy + r[0][2]*cz;
            for (int i = 0; i < 3; i++)
                s[i] = r[0][i] + r[1][i] + r[2][i];
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    m[i][j] = s[i]*s[j] + r[0][i]*r[0][j] + r[1][i]*r[1][j]
                            + r[2][i]*r[2][j];
            for (int i = 0; i < 3; i++)
                diag_acc[i] = clamp_add(diag_acc[i], scaled_product(det, m[i][i]));
            cross_acc[0] = clamp_add(cross_acc[0], scaled_product(det, m[0][1]));
            cross_acc[1] = clamp_add(cross_acc[1], scaled_product(det, m[1][2]));
            cross_acc[2] = clamp_add(cross_acc[2], scaled_product(det, m[0][2]));
            if (!t.last) return;
            res[0] = clamp_add(diag_acc[1], diag_acc[2]) / 120;
            res[1] = clamp_add(diag_acc[0], diag_acc[2]) / 120;
            res[2] = clamp_add(diag_acc[0], diag_acc[1]) / 120;
            res[3] = -(cross_acc[0] / 120);
            res[4] = -(cross_acc[1] / 120);
            res[5] = -(cross_acc[2] / 120);
            tensor_q.push_back(res);
            for (int i = 0; i < 3; i++)
            begin
                diag_acc[i]  = 0;
                cross_acc[i] = 0;
            end
        endfunction

        function void check_tensor(tensor_t got);
            tensor_t exp_t;
            if (tensor_q.size() == 0)
            begin
                $display("%0t: unexpected tensor %h", $time, got);
                errors++;
                return;
            end
            exp_t = tensor_q.pop_front();
            for (int f = 0; f < LANES; f++)
                if (got[f] !== exp_t[f])
                begin
                    $display("%0t: tensor entry %0d expected %0d actual %0d", $time, f,
                             $signed(exp_t[f]), $signed(got[f]));
                    errors++;
                end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [COORD_W-1:0]    cfg_data = '0;

    tensor_scoreboard sb = new();
    bit               idling = 1'b1;
    int               hold_off = 0;
    int               triangles_sent = 0;

    mesh_inertia_tensor_unit DUT (.*);

    always #1 clk = ~clk;

    // sink: random ready bursts, or a long hold-off on request
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off > 0)
            begin
                m_axis_tready <= 1'b0;
                for (n = hold_off, hold_off = 0; n > 0; n--) @(posedge clk);
            end
            if (idling && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // result monitor
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_tensor(m_axis_tdata);

    // limit on the whole run
    initial
    begin
        #5000000;
        $display("mesh_inertia_tensor_unit regression: fail");
        $finish;
    end

    task automatic send_triangle(triangle_t t);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= t.v;
        s_axis_tlast  <= t.last;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_triangle(t);
        triangles_sent++;
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // wait until all tensors are back and any trailing triangle is done
    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge clk);
        repeat (140) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic set_center(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        write_reg(REG_CENTER_X, x);
        write_reg(REG_CENTER_Y, y);
        write_reg(REG_CENTER_Z, z);
    endtask

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            1: return 16'($signed($urandom_range(0, 512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic triangle_t rand_triangle(bit last);
        triangle_t t;
        for (int i = 0; i < N_COORDS; i++)
            t.v[i] = pick_coord();
        t.last = last;
        return t;
    endfunction

    task automatic send_mesh(int len);
        for (int i = 0; i < len; i++)
            send_triangle(rand_triangle(i == len - 1));
    endtask

    task automatic send_uniform(logic [15:0] val, bit last);
        triangle_t t;
        for (int i = 0; i < N_COORDS; i++)
            t.v[i] = val;
        t.last = last;
        send_triangle(t);
    endtask

    // stimulus
    initial
    begin
        triangle_t t;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extreme and degenerate triangles about the origin
        send_uniform(16'h8000, 1'b1);
        send_uniform(16'h7FFF, 1'b1);
        send_uniform(16'h0000, 1'b1);
        t.v = '0;
        t.v[0] = 16'h7FFF; t.v[4] = 16'h7FFF; t.v[8] = 16'h7FFF; t.last = 1'b0;
        send_triangle(t);
        t.v[0] = 16'h8000; t.v[4] = 16'h8000; t.v[8] = 16'h8000; t.last = 1'b1;
        send_triangle(t);
        t.v = '0;
        t.v[0] = 16'h8000; t.v[4] = 16'h7FFF; t.v[8] = 16'h8000; t.last = 1'b1;
        send_triangle(t);
        send_mesh(4);
        stop_sending();
        wait_drained();

        // extreme reference points, plus a write to the unused index
        set_center(16'h8000, 16'h8000, 16'h8000);
        t.v = {16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000,
               16'h8000, 16'h8000, 16'h7FFF};
        t.last = 1'b1;
        send_triangle(t);
        send_uniform(16'h7FFF, 1'b1);
        send_mesh(3);
        stop_sending();
        wait_drained();
        set_center(16'h7FFF, 16'h7FFF, 16'h7FFF);
        write_reg(REG_UNUSED, 16'h1234);
        send_uniform(16'h8000, 1'b1);
        send_mesh(3);
        stop_sending();
        wait_drained();

        // long output hold-off while final triangles keep arriving
        set_center(16'h0100, 16'hFF00, 16'h0000);
        hold_off = 3000;
        for (int i = 0; i < 6; i++)
            send_mesh(1 + (i % 2));
        stop_sending();
        wait_drained();

        // random meshes under a series of reference points
        while (triangles_sent < 1500)
        begin
            if ($urandom_range(0, 2) == 0)
                set_center(pick_coord(), pick_coord(), pick_coord());
            if (triangles_sent > 1300)
                idling = 1'b0;
            repeat ($urandom_range(2, 8))
                send_mesh($urandom_range(0, 3) == 0 ? $urandom_range(5, 20)
                                                    : $urandom_range(1, 4));
            // an unfinished mesh whose sums carry over into the next setting
            if ($urandom_range(0, 4) == 0)
                send_triangle(rand_triangle(1'b0));
            stop_sending();
            wait_drained();
        end

        if (sb.errors == 0)
            $display("mesh_inertia_tensor_unit regression: pass");
        else
            $display("mesh_inertia_tensor_unit regression: fail");
        $finish;
    end

endmodule

### files.f
hdl/mit_pkg.sv
hdl/mit_ctrl.sv
hdl/mit_datapath.sv
hdl/mesh_inertia_tensor_unit.sv
hdl/mit_checker.sv
verif/tb_mesh_inertia_tensor_unit.sv
